/* design/i2cms_pkg.sv */
// Shared types and constants for the I2C master bit sequencer.
// No dependencies; every other design file refers to this package by scoped names.
package i2cms_pkg;

   localparam int unsigned ADDR_W    = 7;
   localparam int unsigned PAYLOAD_W = 24;
   localparam int unsigned COUNT_W   = 2;
   localparam int unsigned RDATA_W   = 16;
   localparam int unsigned BITCNT_W  = 4;
   localparam int unsigned PTR_W     = 5;

   localparam logic [BITCNT_W-1:0] ADDR_MSB_SLOT = 4'd6;
   localparam logic [BITCNT_W-1:0] LAST_BIT_SLOT = 4'd7;
   localparam logic [BITCNT_W-1:0] ACK_SLOT      = 4'd8;
   localparam logic [BITCNT_W-1:0] BYTE_END_SLOT = 4'd9;

   // Item kinds on the request channel
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_START = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE         = 4'd0,
      PH_START_BEGIN  = 4'd1,
      PH_START_MIDDLE = 4'd2,
      PH_START_END    = 4'd3,
      PH_PAUSE_BEGIN  = 4'd4,
      PH_PAUSE        = 4'd5,
      PH_PAUSE_END    = 4'd6,
      PH_TRANSIT      = 4'd7,
      PH_STOP_BEGIN   = 4'd8,
      PH_STOP_MIDDLE  = 4'd9,
      PH_STOP_END     = 4'd10
   } phase_type;

   typedef enum logic [1:0] {
      BK_ADDRESS = 2'd0,
      BK_WDATA   = 2'd1,
      BK_RDATA   = 2'd2
   } byte_kind_type;

   typedef struct packed {
      logic                 kind;
      logic [ADDR_W-1:0]    target_address;
      logic [PAYLOAD_W-1:0] write_payload;
      logic [COUNT_W-1:0]   byte_count;
      logic                 read_xfer;
      logic                 stop_enable;
      logic                 sda_in;
   } req_item_type;

   typedef struct packed {
      logic               scl_out;
      logic               sda_out;
      logic               sda_release;
      logic               ready_res;
      logic [RDATA_W-1:0] read_data;
   } rsp_item_type;

endpackage

/* design/i2cms_channels.sv */
// Valid/ready channel interfaces for the request and result items.
// Depends on i2cms_pkg for field widths.
interface i2cms_req_if;
   logic                            valid;
   logic                            ready;
   logic                            kind;
   logic [i2cms_pkg::ADDR_W-1:0]    target_address;
   logic [i2cms_pkg::PAYLOAD_W-1:0] write_payload;
   logic [i2cms_pkg::COUNT_W-1:0]   byte_count;
   logic                            read_xfer;
   logic                            stop_enable;
   logic                            sda_in;

   modport source (
      output valid, kind, target_address, write_payload, byte_count,
             read_xfer, stop_enable, sda_in,
      input  ready
   );
   modport sink (
      input  valid, kind, target_address, write_payload, byte_count,
             read_xfer, stop_enable, sda_in,
      output ready
   );
endinterface

interface i2cms_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          scl_out;
   logic                          sda_out;
   logic                          sda_release;
   logic                          ready_res;
   logic [i2cms_pkg::RDATA_W-1:0] read_data;

   modport source (
      output valid, scl_out, sda_out, sda_release, ready_res, read_data,
      input  ready
   );
   modport sink (
      input  valid, scl_out, sda_out, sda_release, ready_res, read_data,
      output ready
   );
endinterface

/* design/i2c_master_bit_sequencer_unit.sv */
// I2C master bit sequencer. Each request item is one tick (or a start command that
// replaces a tick) and yields one result item with the line levels after that step.
// The unit takes one item per clock while its output register is free: an input register
// feeds the one-step engine update, whose result lands in an output register. An item
// accepted is stepped once the output register is free, and its result is then offered.
// While a result waits to be taken, the input register takes one more item and then
// holds the request side off until the result moves.
// Depends on i2cms_pkg, i2cms_channels and i2cms_engine.
module i2c_master_bit_sequencer_unit (
   input  logic         clock,
   input  logic         reset,
   i2cms_req_if.sink    req_bus,
   i2cms_rsp_if.source  rsp_bus
);

   logic                    in_valid_ff, in_valid_in;
   i2cms_pkg::req_item_type in_item_ff, in_item_in;
   logic                    out_valid_ff, out_valid_in;
   i2cms_pkg::rsp_item_type out_item_ff, out_item_in;
   i2cms_pkg::rsp_item_type step_result;
   i2cms_pkg::req_item_type req_item;
   logic out_free;
   logic step;
   logic req_take;

   assign req_item.kind           = req_bus.kind;
   assign req_item.target_address = req_bus.target_address;
   assign req_item.write_payload  = req_bus.write_payload;
   assign req_item.byte_count     = req_bus.byte_count;
   assign req_item.read_xfer      = req_bus.read_xfer;
   assign req_item.stop_enable    = req_bus.stop_enable;
   assign req_item.sda_in         = req_bus.sda_in;

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign step          = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || step;
   assign req_take      = req_bus.valid && req_bus.ready;

   i2cms_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .result (step_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      if (step) begin
         out_valid_in = 1'b1;
         out_item_in  = step_result;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.scl_out     = out_item_ff.scl_out;
   assign rsp_bus.sda_out     = out_item_ff.sda_out;
   assign rsp_bus.sda_release = out_item_ff.sda_release;
   assign rsp_bus.ready_res   = out_item_ff.ready_res;
   assign rsp_bus.read_data   = out_item_ff.read_data;

   a_step_fills_output: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("stepped item produced no result");

   a_blocked_input_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_item_ff))
      else $error("input register lost a blocked item");

   a_released_sda_high: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.sda_release |-> out_item_ff.sda_out)
      else $error("released SDA not reported high");

endmodule

/* design/i2cms_engine.sv */
// Bit engine state and its one-step update: START, address, data, ACK and STOP phases.
// Depends on i2cms_pkg; instantiated by i2c_master_bit_sequencer_unit.
module i2cms_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  i2cms_pkg::req_item_type item,
   output i2cms_pkg::rsp_item_type result
);

   i2cms_pkg::phase_type     phase_ff, phase_in;
   i2cms_pkg::byte_kind_type byte_kind_ff, byte_kind_in;
   logic [i2cms_pkg::BITCNT_W-1:0]  bit_counter_ff, bit_counter_in;
   logic [i2cms_pkg::COUNT_W-1:0]   bytes_left_ff, bytes_left_in;
   logic [i2cms_pkg::PTR_W-1:0]     bit_ptr_ff, bit_ptr_in;
   logic [i2cms_pkg::PAYLOAD_W-1:0] tx_shift_ff, tx_shift_in;
   logic [i2cms_pkg::RDATA_W-1:0]   rx_shift_ff, rx_shift_in;
   logic [i2cms_pkg::ADDR_W-1:0]    held_address_ff, held_address_in;
   logic held_direction_ff, held_direction_in;
   logic held_stop_ff, held_stop_in;
   logic sda_level_ff, sda_level_in;
   logic scl_level_ff, scl_level_in;
   logic release_ff, release_in;
   logic ready_flag_ff, ready_flag_in;
   logic [i2cms_pkg::RDATA_W-1:0]   read_hold_ff, read_hold_in;

   logic [i2cms_pkg::PTR_W-1:0] tx_index;
   logic [2:0]                  addr_index;
   logic [i2cms_pkg::ADDR_W:0]  addr_ext;

   // Pointer of 31 (zero byte count) wraps to bit 7
   assign tx_index   = (bit_ptr_ff >= 5'd24) ? bit_ptr_ff - 5'd24 : bit_ptr_ff;
   assign addr_index = i2cms_pkg::ADDR_MSB_SLOT[2:0] - bit_counter_ff[2:0];
   assign addr_ext   = {1'b0, held_address_ff};

   always_comb begin
      phase_in          = phase_ff;
      byte_kind_in      = byte_kind_ff;
      bit_counter_in    = bit_counter_ff;
      bytes_left_in     = bytes_left_ff;
      bit_ptr_in        = bit_ptr_ff;
      tx_shift_in       = tx_shift_ff;
      rx_shift_in       = rx_shift_ff;
      held_address_in   = held_address_ff;
      held_direction_in = held_direction_ff;
      held_stop_in      = held_stop_ff;
      sda_level_in      = sda_level_ff;
      scl_level_in      = scl_level_ff;
      release_in        = release_ff;
      ready_flag_in     = ready_flag_ff;
      read_hold_in      = read_hold_ff;
      if (step) begin
         if (item.kind == i2cms_pkg::KIND_START) begin
            // restart at once: SDA release drops at once, SCL and SDA levels hold until START drives them
            ready_flag_in     = 1'b0;
            phase_in          = i2cms_pkg::PH_START_BEGIN;
            release_in        = 1'b0;
            bit_counter_in    = '0;
            byte_kind_in      = i2cms_pkg::BK_ADDRESS;
            rx_shift_in       = '0;
            held_stop_in      = item.stop_enable;
            tx_shift_in       = item.write_payload;
            held_address_in   = item.target_address;
            held_direction_in = item.read_xfer;
            bytes_left_in     = item.byte_count;
            bit_ptr_in        = 5'({item.byte_count, 3'b000}) - 5'd1;
         end else begin
            unique case (phase_ff)
               i2cms_pkg::PH_START_BEGIN: begin
                  release_in   = 1'b0;
                  sda_level_in = 1'b1;
                  phase_in     = i2cms_pkg::PH_START_MIDDLE;
               end
               i2cms_pkg::PH_START_MIDDLE: begin
                  scl_level_in = 1'b1;
                  phase_in     = i2cms_pkg::PH_START_END;
               end
               i2cms_pkg::PH_START_END: begin
                  sda_level_in = 1'b0;
                  phase_in     = i2cms_pkg::PH_PAUSE_BEGIN;
               end
               i2cms_pkg::PH_PAUSE_BEGIN: begin
                  scl_level_in = 1'b0;
                  if (bit_counter_ff == i2cms_pkg::BYTE_END_SLOT
                        && bytes_left_ff == '0) begin
                     phase_in = i2cms_pkg::PH_STOP_BEGIN;
                  end else begin
                     if (bit_counter_ff == i2cms_pkg::BYTE_END_SLOT) begin
                        if (byte_kind_ff == i2cms_pkg::BK_ADDRESS) begin
                           byte_kind_in = held_direction_ff ? i2cms_pkg::BK_RDATA
                                                            : i2cms_pkg::BK_WDATA;
                        end
                        bit_counter_in = '0;
                     end
                     phase_in = i2cms_pkg::PH_PAUSE;
                  end
               end
               i2cms_pkg::PH_PAUSE: begin
                  if (bit_counter_ff == i2cms_pkg::ACK_SLOT) begin
                     // master ACKs reads, NACK on the last byte
                     sda_level_in = (bytes_left_ff == '0);
                     release_in   = (byte_kind_ff != i2cms_pkg::BK_RDATA);
                  end else begin
                     release_in = (byte_kind_ff == i2cms_pkg::BK_RDATA);
                     if (byte_kind_ff == i2cms_pkg::BK_WDATA) begin
                        sda_level_in = tx_shift_ff[tx_index];
                     end else if (byte_kind_ff == i2cms_pkg::BK_ADDRESS) begin
                        if (bit_counter_ff == i2cms_pkg::LAST_BIT_SLOT) begin
                           sda_level_in = held_direction_ff;
                        end else begin
                           sda_level_in = addr_ext[addr_index];
                        end
                     end
                  end
                  phase_in = i2cms_pkg::PH_PAUSE_END;
               end
               i2cms_pkg::PH_PAUSE_END: begin
                  scl_level_in = 1'b1;
                  phase_in     = i2cms_pkg::PH_TRANSIT;
                  if (byte_kind_ff != i2cms_pkg::BK_ADDRESS
                        && bit_counter_ff == i2cms_pkg::LAST_BIT_SLOT) begin
                     bytes_left_in = bytes_left_ff - 2'd1;
                  end
                  if (bit_counter_ff != i2cms_pkg::ACK_SLOT
                        && byte_kind_ff == i2cms_pkg::BK_WDATA) begin
                     tx_shift_in = {tx_shift_ff[i2cms_pkg::PAYLOAD_W-2:0], 1'b0};
                  end
                  if (bit_counter_ff != i2cms_pkg::ACK_SLOT
                        && byte_kind_ff == i2cms_pkg::BK_RDATA) begin
                     rx_shift_in = {rx_shift_ff[i2cms_pkg::RDATA_W-2:0], 1'b0};
                  end
               end
               i2cms_pkg::PH_TRANSIT: begin
                  if (bit_counter_ff != i2cms_pkg::ACK_SLOT
                        && byte_kind_ff == i2cms_pkg::BK_RDATA) begin
                     rx_shift_in = {rx_shift_ff[i2cms_pkg::RDATA_W-1:1], item.sda_in};
                  end
                  bit_counter_in = bit_counter_ff + 4'd1;
                  phase_in       = i2cms_pkg::PH_PAUSE_BEGIN;
               end
               i2cms_pkg::PH_STOP_BEGIN: begin
                  release_in   = 1'b0;
                  sda_level_in = 1'b0;
                  phase_in     = i2cms_pkg::PH_STOP_MIDDLE;
               end
               i2cms_pkg::PH_STOP_MIDDLE: begin
                  scl_level_in = held_stop_ff;
                  phase_in     = i2cms_pkg::PH_STOP_END;
               end
               i2cms_pkg::PH_STOP_END: begin
                  sda_level_in  = held_stop_ff;
                  ready_flag_in = 1'b1;
                  phase_in      = i2cms_pkg::PH_IDLE;
               end
               default: begin
                  phase_in = i2cms_pkg::PH_IDLE;
               end
            endcase
         end
         if (phase_in == i2cms_pkg::PH_IDLE) begin
            read_hold_in = rx_shift_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= i2cms_pkg::PH_IDLE;
         byte_kind_ff      <= i2cms_pkg::BK_ADDRESS;
         bit_counter_ff    <= '0;
         bytes_left_ff     <= '0;
         bit_ptr_ff        <= '0;
         tx_shift_ff       <= '0;
         rx_shift_ff       <= '0;
         held_address_ff   <= '0;
         held_direction_ff <= 1'b0;
         held_stop_ff      <= 1'b0;
         sda_level_ff      <= 1'b1;
         scl_level_ff      <= 1'b1;
         release_ff        <= 1'b0;
         ready_flag_ff     <= 1'b1;
         read_hold_ff      <= '0;
      end else begin
         phase_ff          <= phase_in;
         byte_kind_ff      <= byte_kind_in;
         bit_counter_ff    <= bit_counter_in;
         bytes_left_ff     <= bytes_left_in;
         bit_ptr_ff        <= bit_ptr_in;
         tx_shift_ff       <= tx_shift_in;
         rx_shift_ff       <= rx_shift_in;
         held_address_ff   <= held_address_in;
         held_direction_ff <= held_direction_in;
         held_stop_ff      <= held_stop_in;
         sda_level_ff      <= sda_level_in;
         scl_level_ff      <= scl_level_in;
         release_ff        <= release_in;
         ready_flag_ff     <= ready_flag_in;
         read_hold_ff      <= read_hold_in;
      end
   end

   // Result reflects the state after this step
   always_comb begin
      result.scl_out     = scl_level_in;
      result.sda_out     = release_in | sda_level_in;
      result.sda_release = release_in;
      result.ready_res   = ready_flag_in;
      result.read_data   = read_hold_in;
   end

   a_idle_is_ready: assert property (@(posedge clock) disable iff (reset)
      phase_ff == i2cms_pkg::PH_IDLE |-> ready_flag_ff)
      else $error("engine idle without ready flag");

   // the release from the last ACK slot lasts until STOP_BEGIN drives the line
   a_release_in_bit_phases: assert property (@(posedge clock) disable iff (reset)
      release_ff |-> (phase_ff == i2cms_pkg::PH_PAUSE_BEGIN || phase_ff == i2cms_pkg::PH_PAUSE
                      || phase_ff == i2cms_pkg::PH_PAUSE_END
                      || phase_ff == i2cms_pkg::PH_TRANSIT
                      || phase_ff == i2cms_pkg::PH_STOP_BEGIN))
      else $error("SDA released outside a bit slot");

   a_bit_counter_range: assert property (@(posedge clock) disable iff (reset)
      bit_counter_ff <= i2cms_pkg::BYTE_END_SLOT)
      else $error("bit counter out of range");

endmodule
